// ===== rtl/qsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsr_pkg: shared types and constants
// Word width, arithmetic unit opcodes, request and response bundles and the
// sequencer states of the quadratic share reconstruction block.
// ----------------------------------------------------------------------------
package qsr_pkg;

    localparam int WORD_BITS  = 32;
    localparam int CNT_W      = $clog2(WORD_BITS);
    localparam int S_TDATA_W  = ((6 * WORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((3 * WORD_BITS + 7) / 8) * 8;
    localparam logic [WORD_BITS-1:0] MODULUS_RESET = WORD_BITS'(64'd2147483647);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        word_t   opa;
        word_t   opb;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        word_t res;
        word_t rem;
    } alu_rsp_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RX1, ST_RY1, ST_RX2, ST_RY2, ST_RX3, ST_RY3,
        ST_SQ1, ST_SQ2, ST_SQ3,
        ST_D1A, ST_D1B, ST_D1R, ST_D2A, ST_D2B, ST_D2R,
        ST_INV_INIT, ST_INV_CHK, ST_INV_DIV, ST_INV_MUL, ST_INV_SUB,
        ST_NINV, ST_K, ST_MKA, ST_FA, ST_MKR, ST_FR,
        ST_A, ST_MB1, ST_MB2, ST_MB3,
        ST_MC1, ST_MC2, ST_MC3, ST_MC4,
        ST_FINISH
    } seq_state_t;

endpackage
`default_nettype wire

// ===== rtl/quadratic_secret_reconstruct.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_secret_reconstruct: threshold-3 share reconstruction
// Solves a*x^2 + b*x + c through three shares over GF(field_modulus).
// ----------------------------------------------------------------------------
// One word of three shares goes in, one word with a, b, the secret c and a
// singular flag comes out. The block takes one word at a time: a sequencer
// runs every step through one shared modular unit. Nine reductions and
// squares, then two inverses by extended Euclid (at most about 46 steps each
// at 32 bits) with eight more multiplies around and after them. A finished
// word waits in the output register while the next one is accepted. The
// modulus is sampled when a word is accepted.
module quadratic_secret_reconstruct
    import qsr_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire [WORD_BITS-1:0]  cfg_wr_data,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // point_x1, point_y1, point_x2, point_y2, point_x3, point_y3
    input  wire [S_TDATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // coef_square, coef_linear, secret
    output logic [M_TDATA_W-1:0] m_tdata,
    // singular
    output logic [0:0]           m_tuser
);

    localparam int W = WORD_BITS;

    seq_state_t state_reg, state_next;
    logic       wait_reg, wait_next;
    logic       inv_sel_reg, sing_reg;
    logic       m_tvalid_reg;
    word_t      modulus_reg, p_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic       m_tuser_reg;

    word_t x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    word_t q1_reg, q2_reg, q3_reg;
    word_t d1a_reg, d1b_reg, d1r_reg, d2a_reg, d2b_reg, d2r_reg;
    word_t r0_reg, r1_reg, t0_reg, t1_reg, qt_reg, nr_reg, tmp_reg, tmp2_reg;
    word_t d1binv_reg, ninv_reg, k_reg, fa_reg, fr_reg, finv_reg;
    word_t a_reg, b_reg, c_reg;

    alu_req_t req;
    alu_rsp_t rsp;
    logic     alu_step;
    logic     accept, out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    qsr_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .modulus (p_reg),
        .req     (req),
        .rsp     (rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept) state_next = (modulus_reg < W'(2)) ? ST_FINISH : ST_RX1;
            ST_RX1:      if (rsp.done) state_next = ST_RY1;
            ST_RY1:      if (rsp.done) state_next = ST_RX2;
            ST_RX2:      if (rsp.done) state_next = ST_RY2;
            ST_RY2:      if (rsp.done) state_next = ST_RX3;
            ST_RX3:      if (rsp.done) state_next = ST_RY3;
            ST_RY3:      if (rsp.done) state_next = ST_SQ1;
            ST_SQ1:      if (rsp.done) state_next = ST_SQ2;
            ST_SQ2:      if (rsp.done) state_next = ST_SQ3;
            ST_SQ3:      if (rsp.done) state_next = ST_D1A;
            ST_D1A:      if (rsp.done) state_next = ST_D1B;
            ST_D1B:      if (rsp.done) state_next = ST_D1R;
            ST_D1R:      if (rsp.done) state_next = ST_D2A;
            ST_D2A:      if (rsp.done) state_next = ST_D2B;
            ST_D2B:      if (rsp.done) state_next = ST_D2R;
            ST_D2R:      if (rsp.done) state_next = ST_INV_INIT;
            ST_INV_INIT: state_next = ST_INV_CHK;
            ST_INV_CHK: begin
                if (r1_reg != '0) begin
                    state_next = ST_INV_DIV;
                end else if (r0_reg != W'(1)) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = inv_sel_reg ? ST_A : ST_NINV;
                end
            end
            ST_INV_DIV:  if (rsp.done) state_next = ST_INV_MUL;
            ST_INV_MUL:  if (rsp.done) state_next = ST_INV_SUB;
            ST_INV_SUB:  if (rsp.done) state_next = ST_INV_CHK;
            ST_NINV:     if (rsp.done) state_next = ST_K;
            ST_K:        if (rsp.done) state_next = ST_MKA;
            ST_MKA:      if (rsp.done) state_next = ST_FA;
            ST_FA:       if (rsp.done) state_next = ST_MKR;
            ST_MKR:      if (rsp.done) state_next = ST_FR;
            ST_FR:       if (rsp.done) state_next = ST_INV_INIT;
            ST_A:        if (rsp.done) state_next = ST_MB1;
            ST_MB1:      if (rsp.done) state_next = ST_MB2;
            ST_MB2:      if (rsp.done) state_next = ST_MB3;
            ST_MB3:      if (rsp.done) state_next = ST_MC1;
            ST_MC1:      if (rsp.done) state_next = ST_MC2;
            ST_MC2:      if (rsp.done) state_next = ST_MC3;
            ST_MC3:      if (rsp.done) state_next = ST_MC4;
            ST_MC4:      if (rsp.done) state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // unit requests per step; multiply operand a must already be reduced
    always_comb begin
        alu_step = 1'b1;
        req.op   = OP_ADD;
        req.opa  = '0;
        req.opb  = '0;
        unique case (state_reg)
            ST_RX1: begin req.op = OP_MUL; req.opa = W'(1); req.opb = x1_reg; end
            ST_RY1: begin req.op = OP_MUL; req.opa = W'(1); req.opb = y1_reg; end
            ST_RX2: begin req.op = OP_MUL; req.opa = W'(1); req.opb = x2_reg; end
            ST_RY2: begin req.op = OP_MUL; req.opa = W'(1); req.opb = y2_reg; end
            ST_RX3: begin req.op = OP_MUL; req.opa = W'(1); req.opb = x3_reg; end
            ST_RY3: begin req.op = OP_MUL; req.opa = W'(1); req.opb = y3_reg; end
            ST_SQ1: begin req.op = OP_MUL; req.opa = x1_reg; req.opb = x1_reg; end
            ST_SQ2: begin req.op = OP_MUL; req.opa = x2_reg; req.opb = x2_reg; end
            ST_SQ3: begin req.op = OP_MUL; req.opa = x3_reg; req.opb = x3_reg; end
            ST_D1A: begin req.op = OP_SUB; req.opa = q1_reg; req.opb = q2_reg; end
            ST_D1B: begin req.op = OP_SUB; req.opa = x1_reg; req.opb = x2_reg; end
            ST_D1R: begin req.op = OP_SUB; req.opa = y1_reg; req.opb = y2_reg; end
            ST_D2A: begin req.op = OP_SUB; req.opa = q2_reg; req.opb = q3_reg; end
            ST_D2B: begin req.op = OP_SUB; req.opa = x2_reg; req.opb = x3_reg; end
            ST_D2R: begin req.op = OP_SUB; req.opa = y2_reg; req.opb = y3_reg; end
            ST_INV_DIV: begin req.op = OP_DIV; req.opa = r1_reg; req.opb = r0_reg; end
            ST_INV_MUL: begin req.op = OP_MUL; req.opa = t1_reg; req.opb = qt_reg; end
            ST_INV_SUB: begin req.op = OP_SUB; req.opa = t0_reg; req.opb = tmp2_reg; end
            ST_NINV: begin req.op = OP_SUB; req.opa = '0; req.opb = d1binv_reg; end
            ST_K:    begin req.op = OP_MUL; req.opa = d2b_reg; req.opb = ninv_reg; end
            ST_MKA:  begin req.op = OP_MUL; req.opa = k_reg; req.opb = d1a_reg; end
            ST_FA:   begin req.op = OP_ADD; req.opa = d2a_reg; req.opb = tmp_reg; end
            ST_MKR:  begin req.op = OP_MUL; req.opa = k_reg; req.opb = d1r_reg; end
            ST_FR:   begin req.op = OP_ADD; req.opa = d2r_reg; req.opb = tmp_reg; end
            ST_A:    begin req.op = OP_MUL; req.opa = fr_reg; req.opb = finv_reg; end
            ST_MB1:  begin req.op = OP_MUL; req.opa = d1a_reg; req.opb = a_reg; end
            ST_MB2:  begin req.op = OP_SUB; req.opa = d1r_reg; req.opb = tmp_reg; end
            ST_MB3:  begin req.op = OP_MUL; req.opa = tmp_reg; req.opb = d1binv_reg; end
            ST_MC1:  begin req.op = OP_MUL; req.opa = b_reg; req.opb = x1_reg; end
            ST_MC2:  begin req.op = OP_MUL; req.opa = a_reg; req.opb = q1_reg; end
            ST_MC3:  begin req.op = OP_ADD; req.opa = tmp_reg; req.opb = tmp2_reg; end
            ST_MC4:  begin req.op = OP_SUB; req.opa = y1_reg; req.opb = tmp_reg; end
            default: alu_step = 1'b0;
        endcase
        req.start = alu_step && !wait_reg;
    end

    always_comb begin
        wait_next = wait_reg;
        if (req.start) wait_next = 1'b1;
        if (rsp.done)  wait_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wait_reg     <= 1'b0;
            inv_sel_reg  <= 1'b0;
            sing_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            modulus_reg  <= MODULUS_RESET;
        end else begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            if (cfg_wr_en) modulus_reg <= cfg_wr_data;
            if (accept) begin
                inv_sel_reg <= 1'b0;
                sing_reg    <= (modulus_reg < W'(2));
            end
            if (state_reg == ST_FR && rsp.done) inv_sel_reg <= 1'b1;
            if (state_reg == ST_INV_CHK && r1_reg == '0 && r0_reg != W'(1)) sing_reg <= 1'b1;
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_reg  <= modulus_reg;
            x1_reg <= s_tdata[0*W +: W];
            y1_reg <= s_tdata[1*W +: W];
            x2_reg <= s_tdata[2*W +: W];
            y2_reg <= s_tdata[3*W +: W];
            x3_reg <= s_tdata[4*W +: W];
            y3_reg <= s_tdata[5*W +: W];
        end
        if (state_reg == ST_INV_INIT) begin
            r0_reg <= p_reg;
            r1_reg <= inv_sel_reg ? fa_reg : d1b_reg;
            t0_reg <= '0;
            t1_reg <= W'(1);
        end
        if (state_reg == ST_INV_CHK && r1_reg == '0) begin
            if (inv_sel_reg) finv_reg <= t0_reg;
            else             d1binv_reg <= t0_reg;
        end
        if (rsp.done) begin
            unique case (state_reg)
                ST_RX1: x1_reg <= rsp.res;
                ST_RY1: y1_reg <= rsp.res;
                ST_RX2: x2_reg <= rsp.res;
                ST_RY2: y2_reg <= rsp.res;
                ST_RX3: x3_reg <= rsp.res;
                ST_RY3: y3_reg <= rsp.res;
                ST_SQ1: q1_reg <= rsp.res;
                ST_SQ2: q2_reg <= rsp.res;
                ST_SQ3: q3_reg <= rsp.res;
                ST_D1A: d1a_reg <= rsp.res;
                ST_D1B: d1b_reg <= rsp.res;
                ST_D1R: d1r_reg <= rsp.res;
                ST_D2A: d2a_reg <= rsp.res;
                ST_D2B: d2b_reg <= rsp.res;
                ST_D2R: d2r_reg <= rsp.res;
                ST_INV_DIV: begin
                    qt_reg <= rsp.res;
                    nr_reg <= rsp.rem;
                end
                ST_INV_MUL: tmp2_reg <= rsp.res;
                ST_INV_SUB: begin
                    t0_reg <= t1_reg;
                    t1_reg <= rsp.res;
                    r0_reg <= r1_reg;
                    r1_reg <= nr_reg;
                end
                ST_NINV: ninv_reg <= rsp.res;
                ST_K:    k_reg <= rsp.res;
                ST_MKA:  tmp_reg <= rsp.res;
                ST_FA:   fa_reg <= rsp.res;
                ST_MKR:  tmp_reg <= rsp.res;
                ST_FR:   fr_reg <= rsp.res;
                ST_A:    a_reg <= rsp.res;
                ST_MB1:  tmp_reg <= rsp.res;
                ST_MB2:  tmp_reg <= rsp.res;
                ST_MB3:  b_reg <= rsp.res;
                ST_MC1:  tmp_reg <= rsp.res;
                ST_MC2:  tmp2_reg <= rsp.res;
                ST_MC3:  tmp_reg <= rsp.res;
                ST_MC4:  c_reg <= rsp.res;
                default: ;
            endcase
        end
        if (state_reg == ST_FINISH && out_free) begin
            m_tuser_reg <= sing_reg;
            if (sing_reg) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= M_TDATA_W'({c_reg, b_reg, a_reg});
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> wait_reg) else $error("unit result not requested");
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0) else $error("singular word not zero");
    a_idle_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !wait_reg) else $error("idle with unit busy");
    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH && out_free |=> m_tvalid) else $error("word not delivered");

endmodule
`default_nettype wire

// ===== rtl/qsr_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsr_alu: shared modular arithmetic unit
// One modular adder with compare-subtract, used for add and for the
// double-and-add multiply; subtract and the restoring divide use other logic.
// ----------------------------------------------------------------------------
module qsr_alu
    import qsr_pkg::*;
(
    input  wire      aclk,
    input  wire      aresetn,
    input  word_t    modulus,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ph_reg, ph_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    alu_op_t          op_reg;
    word_t            a_reg, b_reg, acc_reg;

    logic [WORD_BITS:0] sum_raw, sum_red;
    word_t              add_y, add_out, sub_out;
    logic [WORD_BITS:0] div_sh, div_diff;
    logic               div_ge;

    // shared adder: for multiply doubles acc in phase 0 and adds a in phase 1; for add sums a and b
    always_comb begin
        if (op_reg == OP_MUL && !ph_reg) begin
            add_y = acc_reg;
        end else if (op_reg == OP_MUL) begin
            add_y = a_reg;
        end else begin
            add_y = b_reg;
        end
    end

    always_comb begin
        word_t xa;
        xa = (op_reg == OP_MUL) ? acc_reg : a_reg;
        sum_raw = {1'b0, xa} + {1'b0, add_y};
        sum_red = sum_raw - {1'b0, modulus};
        add_out = (sum_raw >= {1'b0, modulus}) ? sum_red[WORD_BITS-1:0]
                                               : sum_raw[WORD_BITS-1:0];
        sub_out = a_reg - b_reg + ((a_reg < b_reg) ? modulus : '0);
        div_sh   = {acc_reg, b_reg[WORD_BITS-1]};
        div_diff = div_sh - {1'b0, a_reg};
        div_ge   = (div_sh >= {1'b0, a_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ph_next   = ph_reg;
        cnt_next  = cnt_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            ph_next   = 1'b0;
            cnt_next  = '0;
        end else if (busy_reg) begin
            unique case (op_reg)
                OP_ADD, OP_SUB: begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                OP_MUL: begin
                    ph_next = !ph_reg;
                    if (ph_reg) begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == CNT_W'(WORD_BITS - 1)) begin
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                end
                OP_DIV: begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WORD_BITS - 1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ph_reg   <= ph_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            op_reg  <= req.op;
            a_reg   <= req.opa;
            b_reg   <= req.opb;
            acc_reg <= '0;
        end else if (busy_reg) begin
            unique case (op_reg)
                OP_ADD: acc_reg <= add_out;
                OP_SUB: acc_reg <= sub_out;
                OP_MUL: begin
                    if (!ph_reg) begin
                        acc_reg <= add_out;
                    end else begin
                        if (b_reg[WORD_BITS-1]) acc_reg <= add_out;
                        b_reg <= {b_reg[WORD_BITS-2:0], 1'b0};
                    end
                end
                OP_DIV: begin
                    acc_reg <= div_ge ? div_diff[WORD_BITS-1:0] : div_sh[WORD_BITS-1:0];
                    b_reg   <= {b_reg[WORD_BITS-2:0], div_ge};
                end
                default: ;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = (op_reg == OP_DIV) ? b_reg : acc_reg;
    assign rsp.rem  = acc_reg;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg && !done_reg) else $error("start while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without work");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");

endmodule
`default_nettype wire
